// ----- hw/rtl/grf_pkg.sv -----
// ----------------------------------------------------------------------------
// grf_pkg
// Shared constants and helpers for the gyro rate filter.
// ----------------------------------------------------------------------------
package grf_pkg;

    localparam int DIV_NW = 64;
    localparam int DIV_DW = 34;

    localparam logic [30:0] ONE_Q30     = 31'd1073741824;
    localparam logic [31:0] C_BIAS_RATE = 32'd1073742;
    localparam logic [31:0] C_ALPHA     = 32'd10737418;
    localparam logic [31:0] C_ZBLEND    = 32'd53687091;
    localparam logic [31:0] C_GAIN_HI   = 32'd966367642;
    localparam logic [31:0] C_GAIN_LO   = 32'd107374182;
    localparam logic [7:0]  STILL_ARM   = 8'd50;
    localparam logic [7:0]  STILL_MAX   = 8'd255;

    localparam logic [31:0] RST_KALMAN_Q   = 32'd1073742;
    localparam logic [31:0] RST_KALMAN_R   = 32'd32212255;
    localparam logic [31:0] RST_VAR_LIMIT  = 32'd256;
    localparam logic [31:0] RST_MOT_LIMIT  = 32'd655360;
    localparam logic [31:0] RST_COVARIANCE = 32'd1073741824;

    localparam logic [1:0] REG_KALMAN_Q  = 2'd0;
    localparam logic [1:0] REG_KALMAN_R  = 2'd1;
    localparam logic [1:0] REG_VAR_LIMIT = 2'd2;
    localparam logic [1:0] REG_MOT_LIMIT = 2'd3;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [33:0] mag36(input logic signed [35:0] v);
        logic signed [35:0] n;
        n = -v;
        return v[35] ? n[33:0] : v[33:0];
    endfunction

endpackage

// ----- hw/rtl/grf_rate_if.sv -----
// ----------------------------------------------------------------------------
// grf_rate_if
// Input channel: one three-axis raw gyro sample per item.
// ----------------------------------------------------------------------------
interface grf_rate_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;

    modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
    modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

// ----- hw/rtl/grf_filt_if.sv -----
// ----------------------------------------------------------------------------
// grf_filt_if
// Output channel: filtered three-axis rate and still flag per item.
// ----------------------------------------------------------------------------
interface grf_filt_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] filtered_x;
    logic signed [31:0] filtered_y;
    logic signed [31:0] filtered_z;
    logic               still_flag;

    modport source (output valid, output filtered_x, output filtered_y, output filtered_z,
                    output still_flag, input ready);
    modport sink   (input valid, input filtered_x, input filtered_y, input filtered_z,
                    input still_flag, output ready);
endinterface

// ----- hw/rtl/gyro_rate_filter.sv -----
// ----------------------------------------------------------------------------
// gyro_rate_filter
// Per-axis moving average, window variance still detection, static bias
// tracking and scalar Kalman filtering of three-axis gyro samples.
// ----------------------------------------------------------------------------
// One item is in flight at a time; input ready is high only while idle, and a
// finished result waits in an output register while the next item is taken.
// Most of an item's time goes to the history walk, which takes every window
// entry of each axis through the single shared multiplier, and to the shared
// bit-serial divider that forms each of the three Kalman gains; an item may
// also wait for the previous result to be taken. Each average is a reciprocal
// product on the shared multiplier.
module gyro_rate_filter #(
    parameter int AVERAGE_TAPS  = 5,
    parameter int HISTORY_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    grf_rate_if.sink    i_rate,
    grf_filt_if.source  o_filt,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int SUM_W   = 17 + $clog2(AVERAGE_TAPS);
    localparam int TAPS_AW = $clog2(3 * AVERAGE_TAPS);
    localparam int HIST_AW = $clog2(3 * HISTORY_DEPTH);
    localparam int TSLOT_W = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
    localparam int TFILL_W = $clog2(AVERAGE_TAPS + 1);
    localparam int HSLOT_W = $clog2(HISTORY_DEPTH);
    localparam int HFILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int ACC_W   = 48 + HSLOT_W;
    localparam int THR_W   = 32 + HFILL_W;
    localparam int CMP_W   = ACC_W + 1;
    localparam int RECIP_SH = 24;
    localparam logic [31:0] AVG_RECIP = 32'((2**RECIP_SH + AVERAGE_TAPS - 1) / AVERAGE_TAPS);
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [25:0] {
        ST_IDLE = 26'h0000001, ST_TRD  = 26'h0000002, ST_TSUM = 26'h0000004,
        ST_ADIV = 26'h0000008, ST_HWR  = 26'h0000010, ST_HRD  = 26'h0000020,
        ST_HDIF = 26'h0000040, ST_HACC = 26'h0000080, ST_HCMP = 26'h0000100,
        ST_STL  = 26'h0000200, ST_SBM  = 26'h0000400, ST_SBU  = 26'h0000800,
        ST_ZBM  = 26'h0001000, ST_ZBU  = 26'h0002000, ST_KP   = 26'h0004000,
        ST_KDIV = 26'h0008000, ST_KE   = 26'h0010000, ST_KEU  = 26'h0020000,
        ST_KPM  = 26'h0040000, ST_KPU  = 26'h0080000, ST_KBM  = 26'h0100000,
        ST_KBU  = 26'h0200000, ST_OM   = 26'h0400000, ST_OU   = 26'h0800000,
        ST_OV   = 26'h1000000, ST_MUL  = 26'h2000000
    } t_state;

    function automatic logic [15:0] avg_frac(input logic [4:0] rem);
        logic [15:0] f;
        f = '0;
        for (int v = 0; v < AVERAGE_TAPS; v++) begin
            if (rem == 5'(v)) begin
                f = 16'((v * 65536) / AVERAGE_TAPS);
            end
        end
        return f;
    endfunction

    t_state r_state, r_ret;

    logic [31:0] r_kq, r_kr, r_vlim, r_mlim;

    logic signed [15:0]      r_s   [3];
    logic signed [SUM_W-1:0] r_sum [3];
    logic signed [31:0]      r_avg [3];
    logic signed [31:0]      r_sb  [3];
    logic signed [31:0]      r_e   [3];
    logic signed [31:0]      r_kb  [3];
    logic signed [31:0]      r_last[3];
    logic [31:0]             r_cov [3];

    logic signed [15:0] taps_mem [3*AVERAGE_TAPS];
    logic signed [31:0] hist_mem [3*HISTORY_DEPTH];
    logic signed [15:0] r_tq;
    logic signed [31:0] r_hq;

    logic [1:0]         r_axis;
    logic [TSLOT_W-1:0] r_aslot;
    logic [TFILL_W-1:0] r_tfill;
    logic [HSLOT_W-1:0] r_hslot;
    logic [HSLOT_W-1:0] r_j;
    logic [HFILL_W-1:0] r_hfill;
    logic [7:0]         r_cnt;
    logic               r_still;
    logic               r_sneg;
    logic [ACC_W-1:0]   r_acc;
    logic [34:0]        r_motion;
    logic signed [31:0] r_m;
    logic [31:0]        r_p;
    logic [30:0]        r_k;
    logic [33:0]        r_ma;
    logic [31:0]        r_mb;
    logic               r_mneg;
    logic [65:0]        r_prod;

    logic               r_ov;
    logic signed [31:0] r_ox, r_oy, r_oz;
    logic               r_ostill;

    logic [TAPS_AW-1:0] taddr;
    logic [HIST_AW-1:0] hwaddr, hraddr;
    logic               tap_ok;
    logic signed [15:0] tap;
    logic signed [SUM_W-1:0] sum_new;
    logic [SUM_W-1:0]   sum_mag;
    logic [SUM_W-1:0]   avg_quo;
    logic [4:0]         avg_rem;
    logic [35:0]        avg_mag;
    logic signed [36:0] avg_s;
    logic [35:0]        rnd_mag;
    logic signed [36:0] rnd;
    logic signed [31:0] hval;
    logic signed [35:0] hdif;
    logic [33:0]        hmag;
    logic [THR_W-1:0]   thr;
    logic               var_hi;
    logic [7:0]         cnt_new;
    logic [32:0]        p_sum;
    logic [31:0]        p_sat;
    logic [32:0]        den;
    logic signed [35:0] kdif;
    logic signed [35:0] odif;
    logic [31:0]        gain;
    logic               div_start;
    logic [grf_pkg::DIV_NW-1:0] div_nd;
    logic [grf_pkg::DIV_DW-1:0] div_ds;
    logic               div_done;
    logic [grf_pkg::DIV_NW-1:0] div_q;

    assign taddr  = TAPS_AW'(r_axis * AVERAGE_TAPS) + TAPS_AW'(r_aslot);
    assign hwaddr = HIST_AW'(r_axis * HISTORY_DEPTH) + HIST_AW'(r_hslot);
    assign hraddr = HIST_AW'(r_axis * HISTORY_DEPTH) + HIST_AW'(r_j);

    assign tap_ok  = TFILL_W'(r_aslot) < r_tfill;
    assign tap     = tap_ok ? r_tq : 16'sd0;
    assign sum_new = r_sum[r_axis] - SUM_W'(tap) + SUM_W'(r_s[r_axis]);
    assign sum_mag = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

    assign avg_quo = r_prod[RECIP_SH +: SUM_W];
    assign avg_rem = 5'(r_ma[SUM_W-1:0] - SUM_W'(avg_quo * SUM_W'(AVERAGE_TAPS)));
    assign avg_mag = 36'({avg_quo, 16'd0}) + 36'(avg_frac(avg_rem));
    assign avg_s   = r_sneg ? -$signed({1'b0, avg_mag}) : $signed({1'b0, avg_mag});

    assign rnd_mag = 36'((r_prod + 66'(1 << 29)) >> 30);
    assign rnd     = r_mneg ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});

    assign hval   = (HFILL_W'(r_j) < r_hfill) ? r_hq : 32'sd0;
    assign hdif   = 36'(hval) - 36'(r_avg[r_axis]);
    assign hmag   = grf_pkg::mag36(hdif);
    assign thr    = THR_W'(r_vlim) * THR_W'(HISTORY_DEPTH) + THR_W'(HISTORY_DEPTH - 1);
    assign var_hi = (CMP_W'(r_acc) >> 8) > CMP_W'(thr);

    assign cnt_new = !r_still ? 8'd0 :
                     (r_cnt == grf_pkg::STILL_MAX) ? r_cnt : r_cnt + 8'd1;

    assign p_sum = {1'b0, r_cov[r_axis]} + {1'b0, r_kq};
    assign p_sat = p_sum[32] ? 32'hFFFFFFFF : p_sum[31:0];
    assign den   = {1'b0, p_sat} + {1'b0, r_kr};
    assign kdif  = 36'(r_m) - 36'(r_e[r_axis]) - 36'(r_kb[r_axis]);
    assign odif  = 36'(r_e[r_axis]) - 36'(r_last[r_axis]);
    assign gain  = (r_motion > 35'(r_mlim)) ? grf_pkg::C_GAIN_HI : grf_pkg::C_GAIN_LO;

    assign div_start = (r_state == ST_KP) && (den != 33'd0);
    assign div_nd    = grf_pkg::DIV_NW'(p_sat) << 30;
    assign div_ds    = grf_pkg::DIV_DW'(den);

    grf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_nd),
        .i_divisor  (div_ds),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == ST_TSUM) begin
            taps_mem[taddr] <= r_s[r_axis];
        end
        r_tq <= taps_mem[taddr];
        if (r_state == ST_HWR) begin
            hist_mem[hwaddr] <= r_avg[r_axis];
        end
        r_hq <= hist_mem[hraddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_prod <= 66'(r_ma) * 66'(r_mb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kq   <= grf_pkg::RST_KALMAN_Q;
            r_kr   <= grf_pkg::RST_KALMAN_R;
            r_vlim <= grf_pkg::RST_VAR_LIMIT;
            r_mlim <= grf_pkg::RST_MOT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                grf_pkg::REG_KALMAN_Q:  r_kq   <= i_cfg_data;
                grf_pkg::REG_KALMAN_R:  r_kr   <= i_cfg_data;
                grf_pkg::REG_VAR_LIMIT: r_vlim <= i_cfg_data;
                grf_pkg::REG_MOT_LIMIT: r_mlim <= i_cfg_data;
                default: r_kq <= r_kq;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_axis  <= AXIS_X;
            r_aslot <= '0;
            r_tfill <= '0;
            r_hslot <= '0;
            r_hfill <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_still <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i]  <= '0;
                r_sb[i]   <= '0;
                r_e[i]    <= '0;
                r_kb[i]   <= '0;
                r_last[i] <= '0;
                r_cov[i]  <= grf_pkg::RST_COVARIANCE;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_rate.valid) begin
                        r_s[0]   <= i_rate.rate_x;
                        r_s[1]   <= i_rate.rate_y;
                        r_s[2]   <= i_rate.rate_z;
                        r_axis   <= AXIS_X;
                        r_motion <= '0;
                        r_state  <= ST_TRD;
                    end
                end
                ST_TRD: r_state <= ST_TSUM;
                ST_TSUM: begin
                    r_sum[r_axis] <= sum_new;
                    r_sneg        <= sum_new[SUM_W-1];
                    r_ma          <= 34'(sum_mag);
                    r_mb          <= AVG_RECIP;
                    r_ret         <= ST_ADIV;
                    r_state       <= ST_MUL;
                end
                ST_ADIV: begin
                    r_avg[r_axis] <= grf_pkg::sat32(40'(avg_s));
                    if (r_axis == AXIS_Z) begin
                        r_axis  <= AXIS_X;
                        r_aslot <= (r_aslot == TSLOT_W'(AVERAGE_TAPS - 1)) ?
                                   '0 : r_aslot + TSLOT_W'(1);
                        if (r_tfill != TFILL_W'(AVERAGE_TAPS)) begin
                            r_tfill <= r_tfill + TFILL_W'(1);
                        end
                        if (r_hfill != HFILL_W'(HISTORY_DEPTH)) begin
                            r_hfill <= r_hfill + HFILL_W'(1);
                        end
                        r_still <= 1'b1;
                        r_state <= ST_HWR;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= ST_TRD;
                    end
                end
                ST_HWR: begin
                    r_j     <= '0;
                    r_acc   <= '0;
                    r_state <= ST_HRD;
                end
                ST_HRD: r_state <= ST_HDIF;
                ST_HDIF: begin
                    r_ma    <= 34'(hmag[33:8]);
                    r_mb    <= 32'(hmag[33:8]);
                    r_mneg  <= 1'b0;
                    r_ret   <= ST_HACC;
                    r_state <= ST_MUL;
                end
                ST_HACC: begin
                    r_acc <= r_acc + ACC_W'(r_prod[47:0]);
                    if (r_j == HSLOT_W'(HISTORY_DEPTH - 1)) begin
                        r_state <= ST_HCMP;
                    end else begin
                        r_j     <= r_j + HSLOT_W'(1);
                        r_state <= ST_HRD;
                    end
                end
                ST_HCMP: begin
                    if (var_hi) begin
                        r_still <= 1'b0;
                    end
                    if (r_axis == AXIS_Z) begin
                        r_axis  <= AXIS_X;
                        r_hslot <= (r_hslot == HSLOT_W'(HISTORY_DEPTH - 1)) ?
                                   '0 : r_hslot + HSLOT_W'(1);
                        r_state <= ST_STL;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= ST_HWR;
                    end
                end
                ST_STL: begin
                    r_cnt <= cnt_new;
                    if (!r_still) begin
                        r_state <= ST_KP;
                    end else if (cnt_new > grf_pkg::STILL_ARM) begin
                        r_state <= ST_SBM;
                    end else begin
                        r_state <= ST_ZBM;
                    end
                end
                ST_SBM: begin
                    r_ma    <= grf_pkg::mag36(36'(r_avg[r_axis]) - 36'(r_sb[r_axis]));
                    r_mneg  <= r_avg[r_axis] < r_sb[r_axis];
                    r_mb    <= grf_pkg::C_ALPHA;
                    r_ret   <= ST_SBU;
                    r_state <= ST_MUL;
                end
                ST_SBU: begin
                    r_sb[r_axis] <= grf_pkg::sat32(40'(r_sb[r_axis]) + 40'(rnd));
                    if (r_axis == AXIS_Z) begin
                        r_axis  <= AXIS_X;
                        r_state <= ST_ZBM;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= ST_SBM;
                    end
                end
                ST_ZBM: begin
                    r_ma    <= grf_pkg::mag36(36'(r_sb[2]) - 36'(r_kb[2]));
                    r_mneg  <= r_sb[2] < r_kb[2];
                    r_mb    <= grf_pkg::C_ZBLEND;
                    r_ret   <= ST_ZBU;
                    r_state <= ST_MUL;
                end
                ST_ZBU: begin
                    r_kb[2] <= grf_pkg::sat32(40'(r_kb[2]) + 40'(rnd));
                    r_axis  <= AXIS_X;
                    r_state <= ST_KP;
                end
                ST_KP: begin
                    r_m <= grf_pkg::sat32(40'(r_avg[r_axis]) - 40'(r_sb[r_axis]));
                    r_p <= p_sat;
                    r_k <= '0;
                    r_state <= (den != 33'd0) ? ST_KDIV : ST_KE;
                end
                ST_KDIV: begin
                    if (div_done) begin
                        r_k     <= div_q[30:0];
                        r_state <= ST_KE;
                    end
                end
                ST_KE: begin
                    r_ma    <= grf_pkg::mag36(kdif);
                    r_mneg  <= kdif[35];
                    r_mb    <= 32'(r_k);
                    r_ret   <= ST_KEU;
                    r_state <= ST_MUL;
                end
                ST_KEU: begin
                    r_e[r_axis] <= grf_pkg::sat32(40'(r_e[r_axis]) + 40'(rnd));
                    r_state     <= ST_KPM;
                end
                ST_KPM: begin
                    r_ma    <= 34'(r_p);
                    r_mneg  <= 1'b0;
                    r_mb    <= 32'(grf_pkg::ONE_Q30 - r_k);
                    r_ret   <= ST_KPU;
                    r_state <= ST_MUL;
                end
                ST_KPU: begin
                    r_cov[r_axis] <= rnd_mag[31:0];
                    r_state       <= ST_KBM;
                end
                ST_KBM: begin
                    r_ma    <= grf_pkg::mag36(kdif);
                    r_mneg  <= kdif[35];
                    r_mb    <= grf_pkg::C_BIAS_RATE;
                    r_ret   <= ST_KBU;
                    r_state <= ST_MUL;
                end
                ST_KBU: begin
                    r_kb[r_axis] <= grf_pkg::sat32(40'(r_kb[r_axis]) + 40'(rnd));
                    r_motion     <= r_motion + 35'(grf_pkg::mag36(odif));
                    if (r_axis == AXIS_Z) begin
                        r_axis  <= AXIS_X;
                        r_state <= ST_OM;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= ST_KP;
                    end
                end
                ST_OM: begin
                    r_ma    <= grf_pkg::mag36(odif);
                    r_mneg  <= odif[35];
                    r_mb    <= gain;
                    r_ret   <= ST_OU;
                    r_state <= ST_MUL;
                end
                ST_OU: begin
                    r_last[r_axis] <= grf_pkg::sat32(40'(r_last[r_axis]) + 40'(rnd));
                    if (r_axis == AXIS_Z) begin
                        r_axis  <= AXIS_X;
                        r_state <= ST_OV;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= ST_OM;
                    end
                end
                ST_OV: begin
                    if (!r_ov || o_filt.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_MUL: r_state <= r_ret;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == ST_OV && (!r_ov || o_filt.ready)) begin
            r_ov <= 1'b1;
        end else if (o_filt.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OV && (!r_ov || o_filt.ready)) begin
            r_ox     <= r_last[0];
            r_oy     <= r_last[1];
            r_oz     <= r_last[2];
            r_ostill <= r_still;
        end
    end

    assign i_rate.ready      = (r_state == ST_IDLE);
    assign o_filt.valid      = r_ov;
    assign o_filt.filtered_x = r_ox;
    assign o_filt.filtered_y = r_oy;
    assign o_filt.filtered_z = r_oz;
    assign o_filt.still_flag = r_ostill;
endmodule

// ----- hw/rtl/grf_div.sv -----
// ----------------------------------------------------------------------------
// grf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [grf_pkg::DIV_NW-1:0]  i_dividend,
    input  logic [grf_pkg::DIV_DW-1:0]  i_divisor,
    output logic                        o_done,
    output logic [grf_pkg::DIV_NW-1:0]  o_quotient
);
    localparam int CW = $clog2(grf_pkg::DIV_NW);

    logic                       r_busy;
    logic                       r_done;
    logic [CW-1:0]              r_cnt;
    logic [grf_pkg::DIV_DW-1:0] r_dvs;
    logic [grf_pkg::DIV_DW-1:0] r_rem;
    logic [grf_pkg::DIV_NW-1:0] r_quo;
    logic [grf_pkg::DIV_DW:0]   rem_sh;
    logic [grf_pkg::DIV_DW:0]   rem_sub;
    logic                       fits;

    assign rem_sh  = {r_rem, r_quo[grf_pkg::DIV_NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign fits    = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(grf_pkg::DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[grf_pkg::DIV_DW-1:0] : rem_sh[grf_pkg::DIV_DW-1:0];
            r_quo <= {r_quo[grf_pkg::DIV_NW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ----- hw/rtl/grf_checker.sv -----
// ----------------------------------------------------------------------------
// grf_checker
// Port-level checks of the gyro rate filter, bound to the top level.
// ----------------------------------------------------------------------------
module grf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("result appeared while still busy");

    a_no_result_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result appeared as an item started");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in_ready && !i_out_valid))
        else $error("bad state after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");
endmodule

bind gyro_rate_filter grf_checker u_grf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rate.valid),
    .i_in_ready  (i_rate.ready),
    .i_out_valid (o_filt.valid),
    .i_out_ready (o_filt.ready)
);
